@@ design/ttsc_pkg.sv @@
`default_nettype none

package ttsc_pkg;

    localparam int CANVAS_WIDTH  = 320;
    localparam int CANVAS_HEIGHT = 172;
    localparam int MAX_POINTS    = 2;

    localparam int RAW_W = 12;
    localparam int CX_W  = 9;
    localparam int CY_W  = 8;

    localparam logic [RAW_W-1:0] CANVAS_W_RAW = RAW_W'(CANVAS_WIDTH);
    localparam logic [RAW_W-1:0] CANVAS_H_RAW = RAW_W'(CANVAS_HEIGHT);
    localparam logic [CX_W-1:0]  CX_MAX       = CX_W'(CANVAS_WIDTH - 1);
    localparam logic [CY_W-1:0]  CY_MAX       = CY_W'(CANVAS_HEIGHT - 1);
    localparam logic [3:0]       MAX_POINTS_N = 4'(MAX_POINTS);

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 48;

    localparam logic [1:0] CFG_GRACE   = 2'd0;
    localparam logic [1:0] CFG_PRESENT = 2'd1;
    localparam logic [1:0] CFG_SWIPE   = 2'd2;
    localparam logic [1:0] CFG_TAP     = 2'd3;

    localparam logic signed [1:0] SWIPE_NONE  = 2'sb00;
    localparam logic signed [1:0] SWIPE_RIGHT = 2'sb01;
    localparam logic signed [1:0] SWIPE_LEFT  = 2'sb11;

    typedef struct packed {
        logic [31:0] since_start_us;
        logic        read_ok;
        logic [7:0]  count_byte;
        logic [7:0]  x_high_byte;
        logic [7:0]  x_low_byte;
        logic [7:0]  y_high_byte;
        logic [7:0]  y_low_byte;
        logic        collect_swipe;
    } in_item_t;

    typedef struct packed {
        logic [31:0] grace_time_us;
        logic        device_present;
        logic [8:0]  swipe_travel_min;
        logic [8:0]  tap_travel_max;
    } cfg_t;

    typedef struct packed {
        logic             down;
        logic [RAW_W-1:0] rx;
        logic [RAW_W-1:0] ry;
        logic [CX_W-1:0]  cx;
        logic [CY_W-1:0]  cy;
    } report_t;

    typedef struct packed {
        logic              tap_event;
        logic [CX_W-1:0]   tap_x;
        logic [CY_W-1:0]   tap_y;
        logic signed [1:0] swipe_dir;
        logic [RAW_W-1:0]  raw_x;
        logic [RAW_W-1:0]  raw_y;
        logic              finger_down;
    } result_t;

endpackage

`default_nettype wire

@@ design/touch_tap_swipe_classifier.sv @@
// Touch tap and swipe classifier.
// Each item on the s_axis channel is one polled touch report; the block
// answers every report with exactly one item on the m_axis channel that
// carries the tap event, the held tap position, the collected swipe
// direction, the held raw coordinates and the press state.
// The cfg channel writes the four setting registers (grace time, device
// present, swipe and tap thresholds); it is always ready. It is to be
// written only while no report is in flight; the block does not enforce this.
// An accepted report is held in the input register, is classified against
// the gesture state combinationally, and its result is registered in the
// output register once that is free, which raises m_axis_tvalid.
// One report is taken every cycle unless the receiver stalls the output.
// When the receiver holds m_axis_tready low, the result stays in the output
// register, one more report waits in the input register, and s_axis_tready
// then drops until the result is taken.
// Reset clears the gesture state and the held values, empties both
// registers, and loads the setting registers with their defaults.
`default_nettype none

module touch_tap_swipe_classifier
(
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // Fields from bit 0: since_start_us, read_ok, count_byte, x_high_byte,
    // x_low_byte, y_high_byte, y_low_byte, collect_swipe, zero fill.
    input  wire [ttsc_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // Fields from bit 0: tap_event, tap_x, tap_y, swipe_dir, raw_x, raw_y,
    // finger_down, zero fill.
    output logic [ttsc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire [1:0]                           cfg_index,
    input  wire [31:0]                          cfg_data
);

    ttsc_pkg::in_item_t  in_item;
    ttsc_pkg::in_item_t  item_reg;
    logic                item_valid_reg;
    logic                out_valid_reg;
    ttsc_pkg::result_t   out_reg;
    ttsc_pkg::result_t   result;
    ttsc_pkg::cfg_t      cfg_reg;
    ttsc_pkg::report_t   rep;
    logic                step;

    always_comb
    begin
        in_item.since_start_us = s_axis_tdata[31:0];
        in_item.read_ok        = s_axis_tdata[32];
        in_item.count_byte     = s_axis_tdata[40:33];
        in_item.x_high_byte    = s_axis_tdata[48:41];
        in_item.x_low_byte     = s_axis_tdata[56:49];
        in_item.y_high_byte    = s_axis_tdata[64:57];
        in_item.y_low_byte     = s_axis_tdata[72:65];
        in_item.collect_swipe  = s_axis_tdata[73];
    end

    assign step          = item_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !item_valid_reg || step;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_reg.finger_down, out_reg.raw_y, out_reg.raw_x,
                            out_reg.swipe_dir, out_reg.tap_y, out_reg.tap_x,
                            out_reg.tap_event};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grace_time_us    <= 32'd1500000;
            cfg_reg.device_present   <= 1'b1;
            cfg_reg.swipe_travel_min <= 9'd60;
            cfg_reg.tap_travel_max   <= 9'd25;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ttsc_pkg::CFG_GRACE:   cfg_reg.grace_time_us    <= cfg_data;
                ttsc_pkg::CFG_PRESENT: cfg_reg.device_present   <= cfg_data[0];
                ttsc_pkg::CFG_SWIPE:   cfg_reg.swipe_travel_min <= cfg_data[8:0];
                ttsc_pkg::CFG_TAP:     cfg_reg.tap_travel_max   <= cfg_data[8:0];
                default:               cfg_reg.tap_travel_max   <= cfg_reg.tap_travel_max;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            item_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            item_reg <= in_item;
        end
    end

    ttsc_decode u_decode
    (
        .item           (item_reg),
        .device_present (cfg_reg.device_present),
        .rep            (rep)
    );

    ttsc_gesture u_gesture
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .cfg            (cfg_reg),
        .since_start_us (item_reg.since_start_us),
        .collect_swipe  (item_reg.collect_swipe),
        .rep            (rep),
        .result         (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg <= result;
        end
    end

endmodule

`default_nettype wire

@@ design/ttsc_decode.sv @@
`default_nettype none

module ttsc_decode
(
    input  wire ttsc_pkg::in_item_t item,
    input  wire                     device_present,
    output ttsc_pkg::report_t       rep
);

    logic [3:0]                 points;
    logic [ttsc_pkg::RAW_W-1:0] rx;
    logic [ttsc_pkg::RAW_W-1:0] ry;

    always_comb
    begin
        points = item.count_byte[3:0];
        rx     = {item.x_high_byte[3:0], item.x_low_byte};
        ry     = {item.y_high_byte[3:0], item.y_low_byte};

        rep.down = device_present && item.read_ok && (points != 4'd0)
                   && (points <= ttsc_pkg::MAX_POINTS_N);
        rep.rx   = rx;
        rep.ry   = ry;

        // Canvas x comes from raw y and canvas y from raw x.
        if (ry >= ttsc_pkg::CANVAS_W_RAW)
        begin
            rep.cx = ttsc_pkg::CX_MAX;
        end
        else
        begin
            rep.cx = ry[ttsc_pkg::CX_W-1:0];
        end

        if (rx >= ttsc_pkg::CANVAS_H_RAW)
        begin
            rep.cy = ttsc_pkg::CY_MAX;
        end
        else
        begin
            rep.cy = rx[ttsc_pkg::CY_W-1:0];
        end
    end

endmodule

`default_nettype wire

@@ design/ttsc_gesture.sv @@
`default_nettype none

module ttsc_gesture
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     step,
    input  wire ttsc_pkg::cfg_t     cfg,
    input  wire [31:0]              since_start_us,
    input  wire                     collect_swipe,
    input  wire ttsc_pkg::report_t  rep,
    output ttsc_pkg::result_t       result
);

    logic                        pressed_reg, pressed_next;
    logic [ttsc_pkg::CX_W-1:0]   start_x_reg, start_x_next;
    logic [ttsc_pkg::CY_W-1:0]   start_y_reg, start_y_next;
    logic [ttsc_pkg::CX_W-1:0]   latest_x_reg, latest_x_next;
    logic [ttsc_pkg::CY_W-1:0]   latest_y_reg, latest_y_next;
    logic [ttsc_pkg::RAW_W-1:0]  raw_x_reg, raw_x_next;
    logic [ttsc_pkg::RAW_W-1:0]  raw_y_reg, raw_y_next;
    logic signed [1:0]           swipe_reg, swipe_next;
    logic [ttsc_pkg::CX_W-1:0]   tap_x_reg, tap_x_next;
    logic [ttsc_pkg::CY_W-1:0]   tap_y_reg, tap_y_next;

    logic [ttsc_pkg::CX_W:0]     dx;
    logic [ttsc_pkg::CY_W:0]     dy;
    logic [ttsc_pkg::CX_W:0]     ax_full;
    logic [ttsc_pkg::CY_W:0]     ay_full;
    logic [8:0]                  ax;
    logic [8:0]                  ay;
    logic                        is_swipe;
    logic                        is_tap;
    logic                        tap;
    logic signed [1:0]           dir;

    always_comb
    begin
        dx      = {1'b0, latest_x_reg} - {1'b0, start_x_reg};
        dy      = {1'b0, latest_y_reg} - {1'b0, start_y_reg};
        ax_full = dx[ttsc_pkg::CX_W] ? -dx : dx;
        ay_full = dy[ttsc_pkg::CY_W] ? -dy : dy;
        ax      = ax_full[8:0];
        ay      = ay_full[8:0];
        is_swipe = (ax >= cfg.swipe_travel_min) && (ax > ay);
        is_tap   = (ax < cfg.tap_travel_max) && (ay < cfg.tap_travel_max);

        pressed_next  = pressed_reg;
        start_x_next  = start_x_reg;
        start_y_next  = start_y_reg;
        latest_x_next = latest_x_reg;
        latest_y_next = latest_y_reg;
        raw_x_next    = raw_x_reg;
        raw_y_next    = raw_y_reg;
        swipe_next    = swipe_reg;
        tap_x_next    = tap_x_reg;
        tap_y_next    = tap_y_reg;
        tap           = 1'b0;
        dir           = ttsc_pkg::SWIPE_NONE;

        // A touch inside the boot grace period only ends any press.
        if (since_start_us < cfg.grace_time_us)
        begin
            pressed_next = 1'b0;
        end
        else if (rep.down)
        begin
            raw_x_next = rep.rx;
            raw_y_next = rep.ry;
            if (!pressed_reg)
            begin
                pressed_next = 1'b1;
                start_x_next = rep.cx;
                start_y_next = rep.cy;
            end
            latest_x_next = rep.cx;
            latest_y_next = rep.cy;
        end
        else if (pressed_reg)
        begin
            pressed_next = 1'b0;
            if (is_swipe)
            begin
                swipe_next = dx[ttsc_pkg::CX_W] ? ttsc_pkg::SWIPE_LEFT
                                                : ttsc_pkg::SWIPE_RIGHT;
            end
            else if (is_tap)
            begin
                tap        = 1'b1;
                tap_x_next = latest_x_reg;
                tap_y_next = latest_y_reg;
            end
        end

        if (collect_swipe)
        begin
            dir        = swipe_next;
            swipe_next = ttsc_pkg::SWIPE_NONE;
        end

        result.tap_event   = tap;
        result.tap_x       = tap_x_next;
        result.tap_y       = tap_y_next;
        result.swipe_dir   = dir;
        result.raw_x       = raw_x_next;
        result.raw_y       = raw_y_next;
        result.finger_down = pressed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg  <= 1'b0;
            start_x_reg  <= '0;
            start_y_reg  <= '0;
            latest_x_reg <= '0;
            latest_y_reg <= '0;
            raw_x_reg    <= '0;
            raw_y_reg    <= '0;
            swipe_reg    <= ttsc_pkg::SWIPE_NONE;
            tap_x_reg    <= '0;
            tap_y_reg    <= '0;
        end
        else if (step)
        begin
            pressed_reg  <= pressed_next;
            start_x_reg  <= start_x_next;
            start_y_reg  <= start_y_next;
            latest_x_reg <= latest_x_next;
            latest_y_reg <= latest_y_next;
            raw_x_reg    <= raw_x_next;
            raw_y_reg    <= raw_y_next;
            swipe_reg    <= swipe_next;
            tap_x_reg    <= tap_x_next;
            tap_y_reg    <= tap_y_next;
        end
    end

endmodule

`default_nettype wire

@@ tb/tb_touch_tap_swipe_classifier.sv @@
`default_nettype none

module tb_touch_tap_swipe_classifier;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CYCLE_LIMIT = 400000;
    localparam logic [31:0] PAST_GRACE  = 32'd2000000;

    typedef struct {
        ttsc_pkg::in_item_t rep;
        bit                 pinned;
        ttsc_pkg::result_t  want;
    } stim_row_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [ttsc_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [ttsc_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [1:0]                      cfg_index = ttsc_pkg::CFG_GRACE;
    logic [31:0]                     cfg_data = '0;

    // Settings as the block should hold them.
    logic [31:0]       set_grace = 32'd1500000;
    logic              set_present = 1'b1;
    logic [8:0]        set_swipe_min = 9'd60;
    logic [8:0]        set_tap_max = 9'd25;

    // Gesture state of the prediction.
    logic              gest_pressed = 1'b0;
    logic [8:0]        start_x = '0;
    logic [7:0]        start_y = '0;
    logic [8:0]        last_x = '0;
    logic [7:0]        last_y = '0;
    logic [11:0]       held_x = '0;
    logic [11:0]       held_y = '0;
    logic signed [1:0] swipe_held = ttsc_pkg::SWIPE_NONE;
    logic [8:0]        tap_hx = '0;
    logic [7:0]        tap_hy = '0;

    ttsc_pkg::result_t pending_results[$];
    stim_row_t         directed_rows[$];

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int mismatches = 0;
    int results_seen = 0;
    int reports_sent = 0;
    int taps_predicted = 0;
    int swipes_predicted = 0;
    int settings_used = 0;
    int cycle_count = 0;

    touch_tap_swipe_classifier uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles.", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    function automatic ttsc_pkg::result_t classify_report(ttsc_pkg::in_item_t rep);
        logic [11:0]       rx;
        logic [11:0]       ry;
        logic [3:0]        points;
        logic              down;
        logic [8:0]        cx;
        logic [7:0]        cy;
        int                dx;
        int                dy;
        int                ax;
        int                ay;
        ttsc_pkg::result_t res;
        rx = {rep.x_high_byte[3:0], rep.x_low_byte};
        ry = {rep.y_high_byte[3:0], rep.y_low_byte};
        points = rep.count_byte[3:0];
        res = '0;
        if (rep.since_start_us < set_grace)
        begin
            gest_pressed = 1'b0;
        end
        else
        begin
            down = set_present && rep.read_ok && points != 4'd0
                   && points <= ttsc_pkg::MAX_POINTS_N;
            if (down)
            begin
                // Raw y runs along the canvas width and raw x along its height.
                cx = (ry >= ttsc_pkg::CANVAS_W_RAW) ? ttsc_pkg::CX_MAX : ry[8:0];
                cy = (rx >= ttsc_pkg::CANVAS_H_RAW) ? ttsc_pkg::CY_MAX : rx[7:0];
                held_x = rx;
                held_y = ry;
                if (!gest_pressed)
                begin
                    gest_pressed = 1'b1;
                    start_x = cx;
                    start_y = cy;
                end
                last_x = cx;
                last_y = cy;
            end
            else if (gest_pressed)
            begin
                dx = int'(last_x) - int'(start_x);
                dy = int'(last_y) - int'(start_y);
                ax = (dx < 0) ? -dx : dx;
                ay = (dy < 0) ? -dy : dy;
                gest_pressed = 1'b0;
                if (ax >= int'(set_swipe_min) && ax > ay)
                begin
                    swipe_held = (dx > 0) ? ttsc_pkg::SWIPE_RIGHT : ttsc_pkg::SWIPE_LEFT;
                end
                else if (ax < int'(set_tap_max) && ay < int'(set_tap_max))
                begin
                    res.tap_event = 1'b1;
                    tap_hx = last_x;
                    tap_hy = last_y;
                end
            end
        end
        if (rep.collect_swipe)
        begin
            res.swipe_dir = swipe_held;
            swipe_held = ttsc_pkg::SWIPE_NONE;
        end
        res.tap_x = tap_hx;
        res.tap_y = tap_hy;
        res.raw_x = held_x;
        res.raw_y = held_y;
        res.finger_down = gest_pressed;
        return res;
    endfunction

    function automatic ttsc_pkg::in_item_t make_report(logic [31:0] now, logic ok,
                                                       logic [7:0] cnt, logic [15:0] xw,
                                                       logic [15:0] yw, logic collect);
        ttsc_pkg::in_item_t rep;
        rep.since_start_us = now;
        rep.read_ok = ok;
        rep.count_byte = cnt;
        rep.x_high_byte = xw[15:8];
        rep.x_low_byte = xw[7:0];
        rep.y_high_byte = yw[15:8];
        rep.y_low_byte = yw[7:0];
        rep.collect_swipe = collect;
        return rep;
    endfunction

    function automatic ttsc_pkg::result_t fixed_result(logic tap, logic [8:0] tx,
                                                       logic [7:0] ty,
                                                       logic signed [1:0] dir,
                                                       logic [11:0] rxv, logic [11:0] ryv,
                                                       logic down);
        ttsc_pkg::result_t res;
        res.tap_event = tap;
        res.tap_x = tx;
        res.tap_y = ty;
        res.swipe_dir = dir;
        res.raw_x = rxv;
        res.raw_y = ryv;
        res.finger_down = down;
        return res;
    endfunction

    function automatic logic [31:0] pick_now();
        int p;
        p = $urandom_range(0, 99);
        if (p < 6)
            return $urandom;
        if (p < 9)
            return set_grace - 32'd1;
        if (p < 11)
            return set_grace;
        return $urandom_range(set_grace, 32'hFFFF_FFFF);
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("Mismatch in %s of result %0d: expected %0d, got %0d",
                         name, results_seen, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        ttsc_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result %0d: %h", results_seen, m_axis_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("tap_event", int'(want.tap_event), int'(m_axis_tdata[0]));
                check_field("tap_x", int'(want.tap_x), int'(m_axis_tdata[9:1]));
                check_field("tap_y", int'(want.tap_y), int'(m_axis_tdata[17:10]));
                check_field("swipe_dir", int'(want.swipe_dir),
                            int'($signed(m_axis_tdata[19:18])));
                check_field("raw_x", int'(want.raw_x), int'(m_axis_tdata[31:20]));
                check_field("raw_y", int'(want.raw_y), int'(m_axis_tdata[43:32]));
                check_field("finger_down", int'(want.finger_down), int'(m_axis_tdata[44]));
            end
            results_seen++;
        end
    end

    task automatic send_report(ttsc_pkg::in_item_t rep, bit pinned, ttsc_pkg::result_t want);
        ttsc_pkg::result_t predicted;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, rep.collect_swipe, rep.y_low_byte, rep.y_high_byte,
                         rep.x_low_byte, rep.x_high_byte, rep.count_byte, rep.read_ok,
                         rep.since_start_us};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = classify_report(rep);
        if (pinned)
            predicted = want;
        pending_results.push_back(predicted);
        reports_sent++;
        taps_predicted += int'(predicted.tap_event);
        if (predicted.swipe_dir != ttsc_pkg::SWIPE_NONE)
            swipes_predicted++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_setting(logic [1:0] idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            ttsc_pkg::CFG_GRACE:   set_grace = value;
            ttsc_pkg::CFG_PRESENT: set_present = value[0];
            ttsc_pkg::CFG_SWIPE:   set_swipe_min = value[8:0];
            ttsc_pkg::CFG_TAP:     set_tap_max = value[8:0];
            default:               ;
        endcase
    endtask

    task automatic apply_settings(logic [31:0] grace, logic present, logic [8:0] swipe_min,
                                  logic [8:0] tap_max);
        write_setting(ttsc_pkg::CFG_GRACE, grace);
        write_setting(ttsc_pkg::CFG_PRESENT, {31'd0, present});
        write_setting(ttsc_pkg::CFG_SWIPE, {23'd0, swipe_min});
        write_setting(ttsc_pkg::CFG_TAP, {23'd0, tap_max});
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Mostly complete gestures: a press, a few moves in a tap-like, swipe-like
    // or wild pattern, then a release; the rest are arbitrary reports.
    task automatic run_random(int count);
        int sent;
        int rx;
        int ry;
        int steps;
        int style;
        int delta_x;
        int delta_y;
        int pick;
        bit paused;
        sent = 0;
        paused = 1'b0;
        while (sent < count)
        begin
            if (!paused && sent >= count / 2)
            begin
                drain_results();
                paused = 1'b1;
            end
            if ($urandom_range(0, 99) < 12)
            begin
                send_report(make_report($urandom, 1'($urandom), 8'($urandom), 16'($urandom),
                                        16'($urandom), 1'($urandom)), 1'b0, '0);
                sent++;
            end
            else
            begin
                rx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 190);
                ry = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 340);
                steps = $urandom_range(1, 4);
                style = $urandom_range(0, 2);
                repeat (steps)
                begin
                    send_report(make_report(pick_now(), 1'b1,
                                            {4'($urandom), 4'($urandom_range(1, 2))},
                                            {4'($urandom), 12'(rx)}, {4'($urandom), 12'(ry)},
                                            $urandom_range(0, 3) == 0), 1'b0, '0);
                    sent++;
                    case (style)
                        0:
                        begin
                            delta_x = int'($urandom_range(0, 30)) - 15;
                            delta_y = int'($urandom_range(0, 30)) - 15;
                        end
                        1:
                        begin
                            delta_x = int'($urandom_range(0, 20)) - 10;
                            delta_y = int'($urandom_range(20, 160));
                            if ($urandom_range(0, 1))
                                delta_y = -delta_y;
                        end
                        default:
                        begin
                            delta_x = int'($urandom_range(0, 200)) - 100;
                            delta_y = int'($urandom_range(0, 300)) - 150;
                        end
                    endcase
                    rx += delta_x;
                    ry += delta_y;
                    if (rx < 0) rx = 0;
                    if (rx > 4095) rx = 4095;
                    if (ry < 0) ry = 0;
                    if (ry > 4095) ry = 4095;
                end
                pick = $urandom_range(0, 2);
                send_report(make_report(pick_now(), pick != 2,
                                        (pick == 0) ? {4'($urandom), 4'd0} :
                                        (pick == 1) ? {4'($urandom), 4'($urandom_range(3, 15))} :
                                        8'($urandom),
                                        16'($urandom), 16'($urandom), $urandom_range(0, 2) == 0),
                            1'b0, '0);
                sent++;
            end
        end
    endtask

    initial
    begin
        // Reset state with the default settings.
        directed_rows.push_back('{make_report(32'd0, 1'b1, 8'h01, 16'h1234, 16'h5678, 1'b1),
                                  1'b1, fixed_result(1'b0, 9'd0, 8'd0, ttsc_pkg::SWIPE_NONE,
                                                     12'd0, 12'd0, 1'b0)});
        directed_rows.push_back('{make_report(32'hFFFF_FFFF, 1'b1, 8'h01, 16'hFFFF, 16'hFFFF,
                                              1'b0),
                                  1'b1, fixed_result(1'b0, 9'd0, 8'd0, ttsc_pkg::SWIPE_NONE,
                                                     12'hFFF, 12'hFFF, 1'b1)});
        directed_rows.push_back('{make_report(32'hFFFF_FFFF, 1'b0, 8'h01, 16'h0000, 16'h0000,
                                              1'b0),
                                  1'b1, fixed_result(1'b1, 9'd319, 8'd171,
                                                     ttsc_pkg::SWIPE_NONE, 12'hFFF,
                                                     12'hFFF, 1'b0)});
        directed_rows.push_back('{make_report(PAST_GRACE, 1'b1, 8'hF2, 16'hF000, 16'hF000, 1'b0),
                                  1'b0, '0});
        directed_rows.push_back('{make_report(PAST_GRACE, 1'b1, 8'h00, 16'h0000, 16'h0000, 1'b0),
                                  1'b0, '0});
        directed_rows.push_back('{make_report(PAST_GRACE, 1'b1, 8'h03, 16'h0010, 16'h0010, 1'b0),
                                  1'b0, '0});
        // Swipe right at exactly the minimum travel, collected on release.
        directed_rows.push_back('{make_report(PAST_GRACE, 1'b1, 8'h01, 16'd50, 16'd10, 1'b0),
                                  1'b0, '0});
        directed_rows.push_back('{make_report(PAST_GRACE, 1'b1, 8'h11, 16'd50, 16'd70, 1'b0),
                                  1'b0, '0});
        directed_rows.push_back('{make_report(PAST_GRACE, 1'b1, 8'h00, 16'd50, 16'd70, 1'b1),
                                  1'b0, '0});
        // One pixel short of a swipe and too long for a tap.
        directed_rows.push_back('{make_report(PAST_GRACE, 1'b1, 8'h02, 16'd20, 16'd300, 1'b0),
                                  1'b0, '0});
        directed_rows.push_back('{make_report(PAST_GRACE, 1'b1, 8'h02, 16'd20, 16'd241, 1'b0),
                                  1'b0, '0});
        directed_rows.push_back('{make_report(PAST_GRACE, 1'b0, 8'h01, 16'd0, 16'd0, 1'b0),
                                  1'b0, '0});
        // Left swipe left uncollected, overwritten by a right swipe.
        directed_rows.push_back('{make_report(PAST_GRACE, 1'b1, 8'h01, 16'd20, 16'd300, 1'b0),
                                  1'b0, '0});
        directed_rows.push_back('{make_report(PAST_GRACE, 1'b1, 8'h01, 16'd30, 16'd100, 1'b0),
                                  1'b0, '0});
        directed_rows.push_back('{make_report(PAST_GRACE, 1'b1, 8'h00, 16'd0, 16'd0, 1'b0),
                                  1'b0, '0});
        directed_rows.push_back('{make_report(PAST_GRACE, 1'b1, 8'h01, 16'd10, 16'd10, 1'b0),
                                  1'b0, '0});
        directed_rows.push_back('{make_report(PAST_GRACE, 1'b1, 8'h01, 16'd10, 16'd200, 1'b0),
                                  1'b0, '0});
        directed_rows.push_back('{make_report(PAST_GRACE, 1'b1, 8'h04, 16'd0, 16'd0, 1'b0),
                                  1'b0, '0});
        // Collection inside the grace period still reads the latch.
        directed_rows.push_back('{make_report(32'd0, 1'b1, 8'h01, 16'd5, 16'd5, 1'b1),
                                  1'b0, '0});
        // Vertical drag: neither swipe nor tap.
        directed_rows.push_back('{make_report(PAST_GRACE, 1'b1, 8'h01, 16'd0, 16'd50, 1'b0),
                                  1'b0, '0});
        directed_rows.push_back('{make_report(PAST_GRACE, 1'b1, 8'h01, 16'd150, 16'd50, 1'b0),
                                  1'b0, '0});
        directed_rows.push_back('{make_report(PAST_GRACE, 1'b0, 8'h01, 16'd0, 16'd0, 1'b1),
                                  1'b0, '0});
        // A press cut by the grace period leaves no tap on release.
        directed_rows.push_back('{make_report(PAST_GRACE, 1'b1, 8'h01, 16'd5, 16'd5, 1'b0),
                                  1'b0, '0});
        directed_rows.push_back('{make_report(32'd100, 1'b1, 8'h01, 16'd5, 16'd5, 1'b0),
                                  1'b0, '0});
        directed_rows.push_back('{make_report(PAST_GRACE, 1'b0, 8'h00, 16'd5, 16'd5, 1'b1),
                                  1'b0, '0});

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_report(directed_rows[i].rep, directed_rows[i].pinned, directed_rows[i].want);
        drain_results();

        apply_settings(32'd1000, 1'b1, 9'd60, 9'd25);
        src_idle_pct = 0;
        sink_stall_pct = 0;
        run_random(200);
        drain_results();

        apply_settings(32'd0, 1'b1, 9'd0, 9'd511);
        src_idle_pct = 61;
        sink_stall_pct = 0;
        run_random(150);
        drain_results();

        apply_settings(32'hFFFF_FFFF, 1'b1, 9'd511, 9'd0);
        src_idle_pct = 0;
        sink_stall_pct = 61;
        run_random(120);
        drain_results();

        apply_settings(32'd5000, 1'b0, 9'd60, 9'd25);
        src_idle_pct = 13;
        sink_stall_pct = 13;
        run_random(100);
        drain_results();

        apply_settings(32'd1500000, 1'b1, 9'd30, 9'd40);
        src_idle_pct = 61;
        sink_stall_pct = 61;
        run_random(230);
        drain_results();

        apply_settings(32'd200, 1'b1, 9'd100, 9'd10);
        src_idle_pct = 13;
        sink_stall_pct = 13;
        run_random(250);
        drain_results();

        $display("Sent %0d touch reports across %0d register settings and several idle mixes.",
                 reports_sent, settings_used + 1);
        $display("Predicted %0d taps and %0d collected swipes; %0d mismatches.",
                 taps_predicted, swipes_predicted, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
